>>> rtl/rasr_pkg.sv
`default_nettype none
package rasr_pkg;

  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 32;

  // flags carried alongside each word through the queue
  typedef struct packed {
    logic err;
    logic neg;
  } rasr_flags_t;

  localparam int FLAGS_W = $bits(rasr_flags_t);

endpackage
`default_nettype wire

>>> rtl/rasr_queue.sv
`default_nettype none
module rasr_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rasr_front.sv
`default_nettype none
module rasr_front #(
  parameter int W  = 16,
  parameter int MW = 33
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 op,
  input  wire logic [W-1:0]         left_numerator,
  input  wire logic [W-1:0]         left_denominator,
  input  wire logic                 left_negative,
  input  wire logic [W-1:0]         right_numerator,
  input  wire logic [W-1:0]         right_denominator,
  input  wire logic                 right_negative,
  input  wire logic                 q_full,
  output logic                      q_push,
  output logic [MW-1:0]             q_mag,
  output logic [MW-1:0]             q_den,
  output rasr_pkg::rasr_flags_t     q_flags
);
  import rasr_pkg::*;

  logic           a_valid_r, a_valid_nxt;
  logic [2*W-1:0] p1_r, p2_r, den_r;
  logic           lneg_r, rneg_r, err_r;
  logic           accept;
  logic           same_sign, p1_ge;
  logic [2*W:0]   sum;
  logic [2*W+MW:0] sum_ext;
  logic [MW+2*W-1:0] den_ext;

  assign busy   = a_valid_r;
  assign accept = start && !a_valid_r;

  // one registered product per multiplier
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r   <= left_numerator * right_denominator;
      p2_r   <= right_numerator * left_denominator;
      den_r  <= left_denominator * right_denominator;
      lneg_r <= left_negative;
      rneg_r <= right_negative ^ op;
      err_r  <= (left_denominator == '0) || (right_denominator == '0);
    end
  end

  // combine numerators: larger minus smaller on opposite signs
  always_comb begin
    same_sign = (lneg_r == rneg_r);
    p1_ge     = (p1_r >= p2_r);
    if (same_sign) begin
      sum = {1'b0, p1_r} + {1'b0, p2_r};
    end else if (p1_ge) begin
      sum = {1'b0, p1_r} - {1'b0, p2_r};
    end else begin
      sum = {1'b0, p2_r} - {1'b0, p1_r};
    end
    sum_ext       = {{MW{1'b0}}, sum};
    den_ext       = {{MW{1'b0}}, den_r};
    q_mag         = sum_ext[MW-1:0];
    q_den         = den_ext[MW-1:0];
    q_flags.err   = err_r;
    q_flags.neg   = (same_sign || p1_ge) ? lneg_r : rneg_r;
    q_push        = a_valid_r && !q_full;
    a_valid_nxt   = accept || (a_valid_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rasr_back.sv
`default_nettype none
module rasr_back #(
  parameter int MW = 33
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire logic [MW-1:0]                    q_mag,
  input  wire logic [MW-1:0]                    q_den,
  input  wire rasr_pkg::rasr_flags_t            q_flags,
  output logic                                  q_pop,
  output logic                                  out_valid,
  output logic [rasr_pkg::NUM_OUT_W-1:0]        out_num,
  output logic [rasr_pkg::DEN_OUT_W-1:0]        out_den,
  output logic                                  out_neg,
  output logic                                  out_err
);
  import rasr_pkg::*;

  localparam int KW = $clog2(MW + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [MW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0] g_r, g_nxt;
  logic [MW-1:0] nq_r, nq_nxt, dq_r, dq_nxt;
  logic [MW-1:0] nrem_r, nrem_nxt, drem_r, drem_nxt;
  logic          neg_r, neg_nxt;
  logic          ov_r, ov_nxt;
  logic [NUM_OUT_W-1:0] onum_r, onum_nxt;
  logic [DEN_OUT_W-1:0] oden_r, oden_nxt;
  logic          oneg_r, oneg_nxt, oerr_r, oerr_nxt;
  logic [MW:0]   nsh, dsh;
  logic          nbit, dbit;
  logic [MW+NUM_OUT_W-1:0] nq_ext;
  logic [MW+DEN_OUT_W-1:0] dq_ext;

  assign out_valid = ov_r;
  assign out_num   = onum_r;
  assign out_den   = oden_r;
  assign out_neg   = oneg_r;
  assign out_err   = oerr_r;

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r; y_nxt = y_r; k_nxt = k_r; cnt_nxt = cnt_r; g_nxt = g_r;
    nq_nxt = nq_r; dq_nxt = dq_r; nrem_nxt = nrem_r; drem_nxt = drem_r;
    neg_nxt = neg_r;
    ov_nxt = 1'b0;
    onum_nxt = onum_r; oden_nxt = oden_r; oneg_nxt = oneg_r; oerr_nxt = oerr_r;
    q_pop = 1'b0;
    // restoring divide step, both quotients share the divisor
    nsh  = {nrem_r, nq_r[MW-1]};
    dsh  = {drem_r, dq_r[MW-1]};
    nbit = (nsh >= {1'b0, g_r});
    dbit = (dsh >= {1'b0, g_r});
    nq_ext = {{NUM_OUT_W{1'b0}}, nq_r};
    dq_ext = {{DEN_OUT_W{1'b0}}, dq_r};
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_flags.err) begin
            ov_nxt = 1'b1; onum_nxt = '0; oden_nxt = '0;
            oneg_nxt = 1'b0; oerr_nxt = 1'b1;
          end else if (q_mag == '0) begin
            ov_nxt = 1'b1; onum_nxt = '0; oden_nxt = DEN_OUT_W'(1);
            oneg_nxt = 1'b0; oerr_nxt = 1'b0;
          end else begin
            x_nxt = q_mag; y_nxt = q_den; k_nxt = '0;
            nq_nxt = q_mag; dq_nxt = q_den; neg_nxt = q_flags.neg;
            state_nxt = S_GCD;
          end
        end
      end
      S_GCD: begin
        // binary gcd, one shift or subtract a cycle
        if (x_r == y_r) begin
          g_nxt     = x_r << k_r;
          nrem_nxt  = '0;
          drem_nxt  = '0;
          cnt_nxt   = KW'(MW);
          state_nxt = S_DIV;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1; y_nxt = y_r >> 1; k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r > y_r) begin
          x_nxt = x_r - y_r;
        end else begin
          y_nxt = y_r - x_r;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          ov_nxt    = 1'b1;
          onum_nxt  = nq_ext[NUM_OUT_W-1:0];
          oden_nxt  = dq_ext[DEN_OUT_W-1:0];
          oneg_nxt  = neg_r;
          oerr_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          nrem_nxt = nbit ? MW'(nsh - {1'b0, g_r}) : nsh[MW-1:0];
          drem_nxt = dbit ? MW'(dsh - {1'b0, g_r}) : dsh[MW-1:0];
          nq_nxt   = {nq_r[MW-2:0], nbit};
          dq_nxt   = {dq_r[MW-2:0], dbit};
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; k_r <= k_nxt; cnt_r <= cnt_nxt; g_r <= g_nxt;
    nq_r <= nq_nxt; dq_r <= dq_nxt; nrem_r <= nrem_nxt; drem_r <= drem_nxt;
    neg_r <= neg_nxt;
    onum_r <= onum_nxt; oden_r <= oden_nxt; oneg_r <= oneg_nxt; oerr_r <= oerr_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/rational_add_sub_reduce.sv
`default_nettype none
// Path: a zero or error word goes through the front register, the queue write and the
//   back-end pop to its registered strobe; other words add G binary GCD steps and
//   MW = min(2*OPERAND_WIDTH+1, 64) divide steps before that strobe.
// Throughput: one word per back-end run; the shared GCD/divide loop sets it.
// busy is high for one cycle after each accepted word, longer if the queue fills.
// rst_n is synchronous, active low; control clears, the receiver cannot stall.
module rational_add_sub_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [OPERAND_WIDTH-1:0]      in_left_numerator,
  input  wire logic [OPERAND_WIDTH-1:0]      in_left_denominator,
  input  wire logic                          in_left_negative,
  input  wire logic [OPERAND_WIDTH-1:0]      in_right_numerator,
  input  wire logic [OPERAND_WIDTH-1:0]      in_right_denominator,
  input  wire logic                          in_right_negative,
  output logic                               out_valid,
  output logic [rasr_pkg::NUM_OUT_W-1:0]     out_result_numerator,
  output logic [rasr_pkg::DEN_OUT_W-1:0]     out_result_denominator,
  output logic                               out_result_negative,
  output logic                               out_zero_denominator_error
);
  import rasr_pkg::*;

  // numerator sum needs 2W+1 bits; kept modulo 2^64 above that
  localparam int MW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
  localparam int QW = 2 * MW + FLAGS_W;

  logic        q_push, q_full, q_pop, q_valid;
  logic [MW-1:0] f_mag, f_den, b_mag, b_den;
  rasr_flags_t f_flags, b_flags;
  logic [QW-1:0] q_in, q_out;

  // front: cross-multiply, register the products, combine with signs
  rasr_front #(.W(OPERAND_WIDTH), .MW(MW)) u_front (
    .clk, .rst_n, .start, .busy,
    .op(in_op),
    .left_numerator(in_left_numerator),
    .left_denominator(in_left_denominator),
    .left_negative(in_left_negative),
    .right_numerator(in_right_numerator),
    .right_denominator(in_right_denominator),
    .right_negative(in_right_negative),
    .q_full, .q_push, .q_mag(f_mag), .q_den(f_den), .q_flags(f_flags)
  );

  assign q_in = {f_flags, f_mag, f_den};

  // two-word queue decouples front from the reduction loop
  rasr_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .head_valid(q_valid), .head_data(q_out)
  );

  assign b_flags = q_out[QW-1 -: FLAGS_W];
  assign b_mag   = q_out[2*MW-1 -: MW];
  assign b_den   = q_out[MW-1:0];

  // back: GCD then divide both terms (zero and error words skip both), registered result strobe
  rasr_back #(.MW(MW)) u_back (
    .clk, .rst_n, .q_valid, .q_mag(b_mag), .q_den(b_den), .q_flags(b_flags),
    .q_pop, .out_valid,
    .out_num(out_result_numerator),
    .out_den(out_result_denominator),
    .out_neg(out_result_negative),
    .out_err(out_zero_denominator_error)
  );

  // an error word carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_denominator_error |->
      out_result_numerator == '0 && out_result_denominator == '0 && !out_result_negative)
    else $error("error word with non-zero fields");

  // a good word never has a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_denominator_error |-> out_result_denominator != '0)
    else $error("zero denominator on good word");

  // front holds busy in the cycle after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

endmodule
`default_nettype wire

>>> tb/rasr_checker.sv
module rasr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_op,
  input  wire logic [15:0] in_left_numerator,
  input  wire logic [15:0] in_left_denominator,
  input  wire logic        in_left_negative,
  input  wire logic [15:0] in_right_numerator,
  input  wire logic [15:0] in_right_denominator,
  input  wire logic        in_right_negative,
  input  wire logic        out_valid,
  input  wire logic [32:0] out_result_numerator,
  input  wire logic [31:0] out_result_denominator,
  input  wire logic        out_result_negative,
  input  wire logic        out_zero_denominator_error,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [32:0] num;
    logic [31:0] den;
    logic        neg;
    logic        err;
  } fraction_t;

  fraction_t sums_due[$];

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic fraction_t rational_sum(logic sub, logic [15:0] a, logic [15:0] b,
                                             logic an, logic [15:0] c, logic [15:0] d,
                                             logic cn);
    fraction_t   f;
    logic [63:0] p1, p2, mag, den, g;
    logic        rneg, neg;
    f = '0;
    rneg = cn ^ sub;
    if (b == 0 || d == 0) begin
      f.err = 1'b1;
      return f;
    end
    p1  = 64'(a) * 64'(d);
    p2  = 64'(c) * 64'(b);
    den = 64'(b) * 64'(d);
    if (an == rneg) begin
      mag = p1 + p2;
      neg = an;
    end else if (p1 >= p2) begin
      mag = p1 - p2;
      neg = an;
    end else begin
      mag = p2 - p1;
      neg = rneg;
    end
    if (mag == 0) begin
      f.den = 32'd1;
      return f;
    end
    g = euclid(mag, den);
    f.num = 33'(mag / g);
    f.den = 32'(den / g);
    f.neg = neg;
    return f;
  endfunction

  always @(posedge clk) begin
    fraction_t want;
    if (!rst_n) begin
      sums_due.delete();
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (start && !busy)
        sums_due.push_back(rational_sum(in_op, in_left_numerator, in_left_denominator,
                                        in_left_negative, in_right_numerator,
                                        in_right_denominator, in_right_negative));
      if (out_valid) begin
        result_count <= result_count + 1;
        if (sums_due.size() == 0) begin
          $display("%0t: unexpected word num=%0d den=%0d neg=%0b err=%0b", $time,
                   out_result_numerator, out_result_denominator, out_result_negative,
                   out_zero_denominator_error);
          fail_count <= fail_count + 1;
        end else begin
          want = sums_due.pop_front();
          if (want.num !== out_result_numerator || want.den !== out_result_denominator ||
              want.neg !== out_result_negative || want.err !== out_zero_denominator_error) begin
            $display("%0t: mismatch exp num=%0d den=%0d neg=%0b err=%0b", $time,
                     want.num, want.den, want.neg, want.err);
            $display("%0t:          got num=%0d den=%0d neg=%0b err=%0b", $time,
                     out_result_numerator, out_result_denominator, out_result_negative,
                     out_zero_denominator_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= sums_due.size();
  end
endmodule

>>> tb/tb_rational_add_sub_reduce.sv
module tb_rational_add_sub_reduce;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = 1'b0;
  logic [15:0] in_left_numerator = '0;
  logic [15:0] in_left_denominator = '0;
  logic        in_left_negative = 1'b0;
  logic [15:0] in_right_numerator = '0;
  logic [15:0] in_right_denominator = '0;
  logic        in_right_negative = 1'b0;
  logic        out_valid;
  logic [32:0] out_result_numerator;
  logic [31:0] out_result_denominator;
  logic        out_result_negative;
  logic        out_zero_denominator_error;
  int          fail_count, pending_count, result_count;
  int          words_sent = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  rational_add_sub_reduce dut (.*);

  rasr_checker checker_i (.*);

  // picks a 16-bit operand: half fully random, the rest biased to edges and small values
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3, 4:    return 16'($urandom_range(0, 12));
      default: return 16'($urandom);
    endcase
  endfunction

  // present one word and hold it until taken; start stays high into the next
  // word unless an idle gap comes first
  task automatic send_word(logic op, logic [15:0] a, logic [15:0] b, logic an,
                           logic [15:0] c, logic [15:0] d, logic cn, bit gappy);
    if (gappy) begin
      while ($urandom_range(0, 99) < 37) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start                <= 1'b1;
    in_op                <= op;
    in_left_numerator    <= a;
    in_left_denominator  <= b;
    in_left_negative     <= an;
    in_right_numerator   <= c;
    in_right_denominator <= d;
    in_right_negative    <= cn;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    words_sent++;
  endtask

  // random word; denominators zero now and then via pick_operand
  task automatic send_random(bit gappy);
    logic [15:0] b, d;
    b = pick_operand();
    d = pick_operand();
    // keep error words a minority
    if (b == 0 && $urandom_range(0, 3) != 0) b = 16'($urandom_range(1, 65535));
    if (d == 0 && $urandom_range(0, 3) != 0) d = 16'($urandom_range(1, 65535));
    send_word(1'($urandom), pick_operand(), b, 1'($urandom), pick_operand(), d,
              1'($urandom), gappy);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: error, zero results, negative zero, opposite signs, extremes, integers
    send_word(1'b0, 16'd3, 16'd0, 1'b0, 16'd1, 16'd2, 1'b0, 0);
    send_word(1'b1, 16'd3, 16'd4, 1'b1, 16'd1, 16'd0, 1'b1, 0);
    send_word(1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0, 0);
    send_word(1'b1, 16'd1, 16'd2, 1'b0, 16'd2, 16'd4, 1'b0, 0);
    send_word(1'b0, 16'd1, 16'd2, 1'b1, 16'd2, 16'd4, 1'b0, 0);
    send_word(1'b0, 16'd0, 16'd5, 1'b1, 16'd0, 16'd7, 1'b1, 0);
    send_word(1'b0, 16'd1, 16'd3, 1'b0, 16'd2, 16'd3, 1'b1, 0);
    send_word(1'b0, 16'd2, 16'd3, 1'b0, 16'd1, 16'd3, 1'b1, 0);
    send_word(1'b1, 16'd1, 16'd3, 1'b1, 16'd2, 16'd3, 1'b1, 0);
    send_word(1'b0, 16'hFFFF, 16'd1, 1'b0, 16'hFFFF, 16'd1, 1'b0, 0);
    send_word(1'b1, 16'hFFFF, 16'd1, 1'b1, 16'hFFFF, 16'd1, 1'b0, 0);
    send_word(1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFE, 1'b0, 0);
    send_word(1'b0, 16'd1, 16'hFFFF, 1'b0, 16'd1, 16'hFFFE, 1'b1, 0);
    send_word(1'b1, 16'd7, 16'd1, 1'b0, 16'd3, 16'd1, 1'b0, 0);
    send_word(1'b0, 16'hAAAA, 16'h5555, 1'b1, 16'h5555, 16'hAAAA, 1'b0, 0);
    send_word(1'b1, 16'h8000, 16'h8000, 1'b0, 16'h0001, 16'h0001, 1'b1, 0);

    // random with gaps
    repeat (700) send_random(1);
    // sender holds off until the block has drained
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // back-to-back stretch
    repeat (300) send_random(0);
    repeat (730) send_random(1);

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d words (directed edges, zero denominators, zero results, sign mixes)",
             words_sent);
    $display("and checked %0d reduced fractions against the predictor.", result_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog: ~1750 words, with the time limit set well over budget
  initial begin
    #20ms;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end
endmodule
